### rtl/core/sparse_row_jaccard_weight_macros.svh
// Assertion macros shared by the sparse row Jaccard weight RTL.
`ifndef SPARSE_ROW_JACCARD_WEIGHT_MACROS_SVH
`define SPARSE_ROW_JACCARD_WEIGHT_MACROS_SVH

// Same-cycle implication, checked on clk_i, off while rst_ni is low.
`define SRJW_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk_i, off while rst_ni is low.
`define SRJW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/srjw_pkg.sv
// Types and constants for the sparse row Jaccard weight block.
package srjw_pkg;

  localparam int unsigned KindW    = 2;
  localparam int unsigned LdAddrW  = 14;
  localparam int unsigned LdValW   = 15;
  localparam int unsigned RowW     = 10;
  localparam int unsigned StartW   = 15;
  localparam int unsigned ColW     = 10;
  localparam int unsigned WeightW  = 17;
  localparam int unsigned SharedW  = 11;
  localparam int unsigned SharedMax = 2047;

  localparam logic [KindW-1:0] KindLoadStart = 2'd0;
  localparam logic [KindW-1:0] KindLoadCol   = 2'd1;
  localparam logic [KindW-1:0] KindQuery     = 2'd2;

  typedef struct packed {
    logic [KindW-1:0]   kind;
    logic [LdAddrW-1:0] load_address;
    logic [LdValW-1:0]  load_value;
    logic [RowW-1:0]    first_row;
    logic [RowW-1:0]    second_row;
  } req_t;

  typedef struct packed {
    logic [WeightW-1:0] weight;
    logic [SharedW-1:0] shared_count;
    logic               empty_union;
  } rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_START_A,
    S_END_A,
    S_START_B,
    S_END_B,
    S_PREP,
    S_MERGE,
    S_DIV,
    S_DONE
  } state_e;

endpackage

### rtl/core/srjw_div.sv
// Radix-2 restoring divider for the fixed-point Jaccard quotient, one bit a cycle.
module srjw_div #(
  parameter int unsigned DEN_W     = 16,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [DEN_W-1:0]     num_i,
  input  logic [DEN_W-1:0]     den_i,
  output logic                 done_o,
  output logic [FRAC_BITS:0]   quot_o
);

  localparam int unsigned Steps = FRAC_BITS + 1;
  localparam int unsigned CntW  = $clog2(Steps + 1);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [DEN_W:0]    rem_q, rem_d;
  logic [DEN_W-1:0]  den_q, den_d;
  logic [FRAC_BITS:0] quot_q, quot_d;
  logic              ge;
  logic [DEN_W:0]    diff;

  // Numerator never exceeds the denominator, so the quotient fits FRAC_BITS+1 bits.
  always_comb begin
    ge     = (rem_q >= {1'b0, den_q});
    diff   = ge ? (rem_q - {1'b0, den_q}) : rem_q;
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    den_d  = den_q;
    quot_d = quot_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(Steps);
      rem_d  = {1'b0, num_i};
      den_d  = den_i;
    end else if (busy_q) begin
      rem_d  = {diff[DEN_W-1:0], 1'b0};
      quot_d = {quot_q[FRAC_BITS-1:0], ge};
      cnt_d  = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    den_q  <= den_d;
    quot_q <= quot_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

### rtl/core/sparse_row_jaccard_weight.sv
// Query: accept, 4 row start reads, setup, merge, divide, hand-off; the merge compares one
// column pair per cycle. Same row twice or both rows empty skip the divider.
// One request in flight at a time. Loads are written in IDLE and do not stall the input.
// Reset clears control only; both tables are undefined until loaded, no clearing pass.
module sparse_row_jaccard_weight #(
  parameter int unsigned MAX_ROWS    = 1024,
  parameter int unsigned MAX_ENTRIES = 16384,
  parameter int unsigned FRAC_BITS   = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  srjw_pkg::req_t in_req_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output srjw_pkg::rsp_t out_rsp_o
);

  import srjw_pkg::*;

  localparam int unsigned RowAw = $clog2(MAX_ROWS + 1);
  localparam int unsigned ColAw = $clog2(MAX_ENTRIES);
  localparam int unsigned PosW  = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned DenW  = PosW + 1;

  function automatic logic [PosW-1:0] clamp_pos(logic [StartW-1:0] v);
    logic [PosW-1:0] r;
    if (32'(v) > 32'(MAX_ENTRIES)) r = PosW'(MAX_ENTRIES);
    else r = PosW'(v);
    return r;
  endfunction

  function automatic logic [SharedW-1:0] sat_shared(logic [PosW-1:0] v);
    logic [SharedW-1:0] r;
    if (32'(v) > 32'(SharedMax)) r = SharedW'(SharedMax);
    else r = SharedW'(v);
    return r;
  endfunction

  // Table storage
  logic [StartW-1:0] rs_mem  [MAX_ROWS + 1];
  logic [ColW-1:0]   col_mem [MAX_ENTRIES];
  logic [StartW-1:0] rs_rd_q;
  logic [ColW-1:0]   col_rd_a_q, col_rd_b_q;
  logic [RowAw-1:0]  rs_raddr;
  logic [ColAw-1:0]  col_raddr_a, col_raddr_b;

  state_e            state_q, state_d;
  logic              out_valid_q, out_valid_d;
  rsp_t              out_q, out_d;
  rsp_t              res_q, res_d;
  logic [RowW-1:0]   row_a_q, row_a_d, row_b_q, row_b_d;
  logic [PosW-1:0]   sa_q, sa_d, ea_q, ea_d, sb_q, sb_d, eb_q, eb_d;
  logic [PosW-1:0]   ia_q, ia_d, ib_q, ib_d;
  logic [PosW-1:0]   len_a_q, len_a_d, len_b_q, len_b_d;
  logic [PosW-1:0]   shared_q, shared_d;

  logic              in_accept;
  logic [31:0]       ld_addr32;
  logic              ld_start_we, ld_col_we;
  logic              oob_a, oob_b;
  logic [PosW-1:0]   lo_a, hi_a, lo_b, hi_b;
  logic              merge_live;
  logic [DenW-1:0]   den;
  logic              div_start, div_done;
  logic [FRAC_BITS:0] div_quot;
  logic [63:0]       quot_ext, one_ext;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign ld_addr32  = 32'(in_req_i.load_address);
  assign ld_start_we = in_accept && (in_req_i.kind == KindLoadStart)
                       && (ld_addr32 <= 32'(MAX_ROWS));
  assign ld_col_we   = in_accept && (in_req_i.kind == KindLoadCol)
                       && (ld_addr32 < 32'(MAX_ENTRIES));

  assign oob_a = (32'(row_a_q) >= 32'(MAX_ROWS));
  assign oob_b = (32'(row_b_q) >= 32'(MAX_ROWS));
  assign lo_a  = oob_a ? '0 : sa_q;
  assign hi_a  = oob_a ? '0 : ((ea_q < sa_q) ? sa_q : ea_q);
  assign lo_b  = oob_b ? '0 : sb_q;
  assign hi_b  = oob_b ? '0 : ((eb_q < sb_q) ? sb_q : eb_q);

  assign merge_live = (ia_q < ea_q) && (ib_q < eb_q);
  assign den = DenW'(len_a_q) + DenW'(len_b_q) - DenW'(shared_q);
  assign div_start = (state_q == S_MERGE) && !merge_live && (den != '0);
  assign quot_ext = 64'(div_quot);
  assign one_ext  = 64'(1) << FRAC_BITS;

  // Row start reads walk start[a], start[a+1], start[b], start[b+1].
  always_comb begin
    logic [31:0] a32;
    a32 = '0;
    unique case (state_q)
      S_IDLE:    a32 = 32'(in_req_i.first_row);
      S_START_A: a32 = 32'(row_a_q) + 32'd1;
      S_END_A:   a32 = 32'(row_b_q);
      S_START_B: a32 = 32'(row_b_q) + 32'd1;
      default:   a32 = '0;
    endcase
    rs_raddr = a32[RowAw-1:0];
  end

  // Column reads follow the next merge positions so data lines up with ia_q/ib_q.
  always_comb begin
    logic [31:0] a32, b32;
    a32 = 32'(ia_d);
    b32 = 32'(ib_d);
    col_raddr_a = (a32 < 32'(MAX_ENTRIES)) ? a32[ColAw-1:0] : '0;
    col_raddr_b = (b32 < 32'(MAX_ENTRIES)) ? b32[ColAw-1:0] : '0;
  end

  always_ff @(posedge clk_i) begin
    if (ld_start_we) begin
      rs_mem[ld_addr32[RowAw-1:0]] <= in_req_i.load_value[StartW-1:0];
    end
    rs_rd_q <= rs_mem[rs_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (ld_col_we) begin
      col_mem[ld_addr32[ColAw-1:0]] <= in_req_i.load_value[ColW-1:0];
    end
    col_rd_a_q <= col_mem[col_raddr_a];
    col_rd_b_q <= col_mem[col_raddr_b];
  end

  srjw_div #(
    .DEN_W     (DenW),
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (DenW'(shared_q)),
    .den_i   (den),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    res_d       = res_q;
    row_a_d     = row_a_q;
    row_b_d     = row_b_q;
    sa_d        = sa_q;
    ea_d        = ea_q;
    sb_d        = sb_q;
    eb_d        = eb_q;
    ia_d        = ia_q;
    ib_d        = ib_q;
    len_a_d     = len_a_q;
    len_b_d     = len_b_q;
    shared_d    = shared_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_accept && (in_req_i.kind == KindQuery)) begin
          row_a_d = in_req_i.first_row;
          row_b_d = in_req_i.second_row;
          state_d = S_START_A;
        end
      end
      S_START_A: begin
        sa_d    = clamp_pos(rs_rd_q);
        state_d = S_END_A;
      end
      S_END_A: begin
        ea_d    = clamp_pos(rs_rd_q);
        state_d = S_START_B;
      end
      S_START_B: begin
        sb_d    = clamp_pos(rs_rd_q);
        state_d = S_END_B;
      end
      S_END_B: begin
        eb_d    = clamp_pos(rs_rd_q);
        state_d = S_PREP;
      end
      S_PREP: begin
        ia_d     = lo_a;
        ib_d     = lo_b;
        ea_d     = hi_a;
        eb_d     = hi_b;
        len_a_d  = hi_a - lo_a;
        len_b_d  = hi_b - lo_b;
        shared_d = '0;
        if (row_a_q == row_b_q) begin
          res_d.weight       = one_ext[WeightW-1:0];
          res_d.shared_count = sat_shared(hi_a - lo_a);
          res_d.empty_union  = 1'b0;
          state_d            = S_DONE;
        end else begin
          state_d = S_MERGE;
        end
      end
      S_MERGE: begin
        if (merge_live) begin
          if (col_rd_a_q == col_rd_b_q) shared_d = shared_q + PosW'(1);
          if (col_rd_a_q <= col_rd_b_q) ia_d = ia_q + PosW'(1);
          if (col_rd_b_q <= col_rd_a_q) ib_d = ib_q + PosW'(1);
        end else if (den == '0) begin
          res_d.weight       = '0;
          res_d.shared_count = '0;
          res_d.empty_union  = 1'b1;
          state_d            = S_DONE;
        end else begin
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          res_d.weight       = quot_ext[WeightW-1:0];
          res_d.shared_count = sat_shared(shared_q);
          res_d.empty_union  = 1'b0;
          state_d            = S_DONE;
        end
      end
      S_DONE: begin
        // Hold until the output register is free or drains this cycle.
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_d       = res_q;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q    <= out_d;
    res_q    <= res_d;
    row_a_q  <= row_a_d;
    row_b_q  <= row_b_d;
    sa_q     <= sa_d;
    ea_q     <= ea_d;
    sb_q     <= sb_d;
    eb_q     <= eb_d;
    ia_q     <= ia_d;
    ib_q     <= ib_d;
    len_a_q  <= len_a_d;
    len_b_q  <= len_b_d;
    shared_q <= shared_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

`include "sparse_row_jaccard_weight_macros.svh"

  `SRJW_ASSERT_NOW(a_merge_in_bounds, state_q == S_MERGE, (ia_q <= ea_q) && (ib_q <= eb_q), "merge position ran past row end")
  `SRJW_ASSERT_NOW(a_shared_le_len, state_q == S_MERGE, (shared_q <= len_a_q) && (shared_q <= len_b_q), "shared count exceeds a row length")
  `SRJW_ASSERT_NOW(a_div_done_in_div, div_done, state_q == S_DIV, "divider finished outside divide state")
  `SRJW_ASSERT_NEXT(a_query_starts, in_accept && (in_req_i.kind == KindQuery), state_q == S_START_A, "query accepted but row reads not started")

endmodule
